[hdl/efr_pkg.sv]
// Shared types, codes and defaults for the framed byte receiver.
// No dependencies; used by every module of the block except efr_ram.
`default_nettype none

package efr_pkg;

  // Default buffer size in payload bytes
  localparam int unsigned MAX_PAYLOAD_DEF = 64;

  // Byte and configuration widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Marker reset values
  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h02;
  localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h03;

  // Register indexes (byte address / 4)
  localparam logic CFG_IDX_START = 1'b0;
  localparam logic CFG_IDX_END   = 1'b1;

  // Request types
  typedef enum logic [1:0] {
    REQ_BYTE    = 2'd0,
    REQ_RESTART = 2'd1,
    REQ_READ    = 2'd2
  } req_t;

  // Event codes reported with each result
  typedef enum logic [3:0] {
    EV_IDLE_SKIP = 4'd0,
    EV_START     = 4'd1,
    EV_LEN_OK    = 4'd2,
    EV_DATA      = 4'd3,
    EV_CHK_OK    = 4'd4,
    EV_DONE      = 4'd5,
    EV_LEN_ERR   = 4'd6,
    EV_CHK_ERR   = 4'd7,
    EV_END_ERR   = 4'd8,
    EV_RESTART   = 4'd9,
    EV_IGNORED   = 4'd10
  } ev_t;

  // Receive phase, one-hot
  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_LEN   = 7'b0000010,
    PH_FIRST = 7'b0000100,
    PH_DATA  = 7'b0001000,
    PH_CHK   = 7'b0010000,
    PH_END   = 7'b0100000,
    PH_READY = 7'b1000000
  } phase_t;

  // Phase codes as seen on the result port
  localparam logic [2:0] PHC_IDLE  = 3'd0;
  localparam logic [2:0] PHC_LEN   = 3'd1;
  localparam logic [2:0] PHC_FIRST = 3'd2;
  localparam logic [2:0] PHC_DATA  = 3'd3;
  localparam logic [2:0] PHC_CHK   = 3'd4;
  localparam logic [2:0] PHC_END   = 3'd5;
  localparam logic [2:0] PHC_READY = 3'd6;

  // Status of one processed request
  typedef struct packed {
    ev_t        ev;
    logic       ready;
    logic [2:0] phase_code;
  } status_t;

  // One-hot phase to external code
  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    unique case (ph)
      PH_IDLE:  code = PHC_IDLE;
      PH_LEN:   code = PHC_LEN;
      PH_FIRST: code = PHC_FIRST;
      PH_DATA:  code = PHC_DATA;
      PH_CHK:   code = PHC_CHK;
      PH_END:   code = PHC_END;
      PH_READY: code = PHC_READY;
      default:  code = PHC_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

[hdl/efr_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module efr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/efr_cfg.sv]
// APB-style register file for the start and end marker bytes.
// Depends on efr_pkg.
`default_nettype none

module efr_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [efr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [efr_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [efr_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                   pready,
  output logic      [efr_pkg::BYTE_W-1:0]        start_marker,
  output logic      [efr_pkg::BYTE_W-1:0]        end_marker
);

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  // Marker registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= efr_pkg::START_MARKER_RST;
      end_marker   <= efr_pkg::END_MARKER_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        efr_pkg::CFG_IDX_START: start_marker <= pwdata[efr_pkg::BYTE_W-1:0];
        efr_pkg::CFG_IDX_END:   end_marker   <= pwdata[efr_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      efr_pkg::CFG_IDX_START: prdata[efr_pkg::BYTE_W-1:0] = start_marker;
      efr_pkg::CFG_IDX_END:   prdata[efr_pkg::BYTE_W-1:0] = end_marker;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[hdl/efr_fsm.sv]
// Frame receive state machine: phase, counters, checksum, ready flag,
// and the payload write request. Depends on efr_pkg.
`default_nettype none

module efr_fsm #(
  parameter int unsigned MAX_PAYLOAD = efr_pkg::MAX_PAYLOAD_DEF,
  localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1),
  localparam int unsigned IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire logic [1:0]                  req_type,
  input  wire logic [efr_pkg::BYTE_W-1:0]  rx_byte,
  input  wire logic [efr_pkg::BYTE_W-1:0]  start_marker,
  input  wire logic [efr_pkg::BYTE_W-1:0]  end_marker,
  output logic      [LEN_W-1:0]            frame_length,
  output logic      [LEN_W-1:0]            frame_length_next,
  output efr_pkg::status_t                 status,
  output logic                             wr_en,
  output logic      [IDX_W-1:0]            wr_addr,
  output logic      [efr_pkg::BYTE_W-1:0]  wr_data
);

  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_PAYLOAD);
  localparam logic [8:0]       MAX_LEN9 = 9'(MAX_PAYLOAD);

  efr_pkg::phase_t             phase, phase_next;
  logic [LEN_W-1:0]            byte_count, byte_count_next;
  logic [efr_pkg::BYTE_W-1:0]  checksum, checksum_next;
  logic                        ready_flag, ready_flag_next;
  efr_pkg::ev_t                ev;
  logic                        wr_req;
  logic [LEN_W-1:0]            count_inc;
  logic                        start_hit;

  assign count_inc = byte_count + LEN_W'(1);
  assign start_hit = (rx_byte == start_marker);

  // Next-state logic
  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    frame_length_next = frame_length;
    checksum_next     = checksum;
    ready_flag_next   = ready_flag;
    ev                = efr_pkg::EV_IGNORED;
    wr_req            = 1'b0;

    unique case (efr_pkg::req_t'(req_type))
      efr_pkg::REQ_RESTART: begin
        phase_next        = efr_pkg::PH_IDLE;
        byte_count_next   = '0;
        frame_length_next = '0;
        checksum_next     = '0;
        ready_flag_next   = 1'b0;
        ev                = efr_pkg::EV_RESTART;
      end
      efr_pkg::REQ_BYTE: begin
        unique case (phase)
          efr_pkg::PH_IDLE: begin
            if (start_hit) begin
              ready_flag_next = 1'b0;
              byte_count_next = '0;
              checksum_next   = '0;
              phase_next      = efr_pkg::PH_LEN;
              ev              = efr_pkg::EV_START;
            end else begin
              ev = efr_pkg::EV_IDLE_SKIP;
            end
          end
          efr_pkg::PH_LEN: begin
            if ({1'b0, rx_byte} > MAX_LEN9) begin
              phase_next        = efr_pkg::PH_IDLE;
              byte_count_next   = '0;
              frame_length_next = '0;
              checksum_next     = '0;
              ready_flag_next   = 1'b0;
              ev                = efr_pkg::EV_LEN_ERR;
            end else begin
              frame_length_next = LEN_W'(rx_byte);
              phase_next = (rx_byte == '0) ? efr_pkg::PH_CHK : efr_pkg::PH_FIRST;
              ev         = efr_pkg::EV_LEN_OK;
            end
          end
          efr_pkg::PH_FIRST, efr_pkg::PH_DATA: begin
            if (start_hit) begin
              phase_next        = efr_pkg::PH_LEN;
              byte_count_next   = '0;
              frame_length_next = '0;
              checksum_next     = '0;
              ready_flag_next   = 1'b0;
              ev                = efr_pkg::EV_START;
            end else begin
              wr_req          = (byte_count < MAX_LEN);
              checksum_next   = checksum ^ rx_byte;
              byte_count_next = count_inc;
              phase_next = (count_inc >= frame_length) ? efr_pkg::PH_CHK
                                                       : efr_pkg::PH_DATA;
              ev         = efr_pkg::EV_DATA;
            end
          end
          efr_pkg::PH_CHK: begin
            if (start_hit) begin
              phase_next        = efr_pkg::PH_LEN;
              byte_count_next   = '0;
              frame_length_next = '0;
              checksum_next     = '0;
              ready_flag_next   = 1'b0;
              ev                = efr_pkg::EV_START;
            end else if (rx_byte == checksum) begin
              phase_next = efr_pkg::PH_END;
              ev         = efr_pkg::EV_CHK_OK;
            end else begin
              phase_next        = efr_pkg::PH_IDLE;
              byte_count_next   = '0;
              frame_length_next = '0;
              checksum_next     = '0;
              ready_flag_next   = 1'b0;
              ev                = efr_pkg::EV_CHK_ERR;
            end
          end
          efr_pkg::PH_END: begin
            if (rx_byte == end_marker) begin
              ready_flag_next = 1'b1;
              phase_next      = efr_pkg::PH_READY;
              ev              = efr_pkg::EV_DONE;
            end else begin
              phase_next        = efr_pkg::PH_IDLE;
              byte_count_next   = '0;
              frame_length_next = '0;
              checksum_next     = '0;
              ready_flag_next   = 1'b0;
              ev                = efr_pkg::EV_END_ERR;
            end
          end
          // ready: hold the frame, ignore line bytes
          default: ev = efr_pkg::EV_IGNORED;
        endcase
      end
      // read request or unused code: no state change
      default: ev = efr_pkg::EV_IGNORED;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= efr_pkg::PH_IDLE;
      byte_count   <= '0;
      frame_length <= '0;
      checksum     <= '0;
      ready_flag   <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      frame_length <= frame_length_next;
      checksum     <= checksum_next;
      ready_flag   <= ready_flag_next;
    end
  end

  // Result status and payload write request
  assign status.ev         = ev;
  assign status.ready      = ready_flag_next;
  assign status.phase_code = efr_pkg::phase_code(phase_next);
  assign wr_en             = step & wr_req;
  assign wr_addr           = byte_count[IDX_W-1:0];
  assign wr_data           = rx_byte;

endmodule

`default_nettype wire

[hdl/stx_etx_frame_receiver_top.sv]
// Top level of the framed byte receiver: input register, state machine,
// payload RAM, result register and marker registers.
// Depends on efr_pkg, efr_ram, efr_cfg and efr_fsm.
`default_nettype none

// Receives a byte stream framed as start marker, length, payload, XOR
// checksum and end marker, one request per cycle unless in_stall is high.
// Every accepted request (line byte, restart, or payload read) produces
// exactly one result: it is held in the input register, while the payload
// RAM does its registered read addressed straight from the request port,
// and then goes through the state machine into the result register. A new
// request is taken every cycle while results are drained; a stalled result
// holds the input register, so at most two requests are in flight. A write
// to the RAM by the request just ahead of a read is forwarded. After a
// complete frame the block reports ready and ignores line bytes until a
// restart request. Reading a payload position below the length that was
// never written returns an undefined byte. The user must change markers over
// the APB port only while no request is in flight; the block does not enforce it.
module stx_etx_frame_receiver_top #(
  parameter int unsigned MAX_PAYLOAD = efr_pkg::MAX_PAYLOAD_DEF,
  localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1),
  localparam int unsigned IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // request channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        req_type,
  input  wire logic [efr_pkg::BYTE_W-1:0]        rx_byte,
  input  wire logic [IDX_W-1:0]                  read_index,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [3:0]                        event_code,
  output logic                                   packet_ready,
  output logic      [LEN_W-1:0]                  packet_length,
  output logic      [efr_pkg::BYTE_W-1:0]        read_data,
  output logic      [2:0]                        receive_phase,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [efr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [efr_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [efr_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                   pready
);

  logic                        accept;
  logic                        s1_valid;
  logic                        s1_adv;
  logic                        step;
  logic [1:0]                  s1_req;
  logic [efr_pkg::BYTE_W-1:0]  s1_byte;
  logic [IDX_W-1:0]            s1_idx;
  logic                        s1_byp;
  logic [efr_pkg::BYTE_W-1:0]  s1_byp_data;

  logic [efr_pkg::BYTE_W-1:0]  start_marker;
  logic [efr_pkg::BYTE_W-1:0]  end_marker;
  logic [LEN_W-1:0]            frame_length;
  logic [LEN_W-1:0]            frame_length_next;
  efr_pkg::status_t            status;
  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [efr_pkg::BYTE_W-1:0]  ram_wdata;
  logic [efr_pkg::BYTE_W-1:0]  ram_q;
  logic [efr_pkg::BYTE_W-1:0]  rd_value;

  // Handshake control
  assign s1_adv   = ~out_valid | ~out_stall;
  assign step     = s1_valid & s1_adv;
  assign in_stall = s1_valid & ~s1_adv;
  assign accept   = in_valid & ~in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req      <= req_type;
      s1_byte     <= rx_byte;
      s1_idx      <= read_index;
      s1_byp      <= ram_we & (ram_waddr == read_index);
      s1_byp_data <= ram_wdata;
    end
  end

  // Marker registers
  efr_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start_marker (start_marker),
    .end_marker   (end_marker)
  );

  // Receive state machine
  efr_fsm #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_fsm (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .req_type          (s1_req),
    .rx_byte           (s1_byte),
    .start_marker      (start_marker),
    .end_marker        (end_marker),
    .frame_length      (frame_length),
    .frame_length_next (frame_length_next),
    .status            (status),
    .wr_en             (ram_we),
    .wr_addr           (ram_waddr),
    .wr_data           (ram_wdata)
  );

  // Payload store, read issued at request accept
  efr_ram #(
    .WIDTH (efr_pkg::BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (read_index),
    .rdata (ram_q)
  );

  // Read data: stored byte below the current length, else zero
  always_comb begin
    rd_value = '0;
    if ((efr_pkg::req_t'(s1_req) == efr_pkg::REQ_READ) &&
        (LEN_W'(s1_idx) < frame_length)) begin
      rd_value = s1_byp ? s1_byp_data : ram_q;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      event_code    <= status.ev;
      packet_ready  <= status.ready;
      packet_length <= frame_length_next;
      read_data     <= rd_value;
      receive_phase <= status.phase_code;
    end
  end

`ifndef SYNTHESIS
  // Ready is reported exactly in the ready phase
  a_ready_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (packet_ready == (receive_phase == efr_pkg::PHC_READY)))
    else $error("packet_ready disagrees with receive_phase");

  // Payload writes only happen when a request moves to the result register
  a_write_on_step: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> step)
    else $error("payload write without a processed request");

  // Held length never exceeds the buffer
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (packet_length <= LEN_W'(MAX_PAYLOAD)))
    else $error("packet_length above buffer size");

  // Non-zero read data comes only from an ignored-event request
  a_read_event: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (read_data != '0)) |-> (event_code == efr_pkg::EV_IGNORED))
    else $error("read data on a non-read result");

  // A request taken into an empty input register is held there next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (accept && !s1_valid) |=> s1_valid)
    else $error("accepted request lost in input register");
`endif

endmodule

`default_nettype wire
